// ===== sv/mhpq_pkg.sv =====
// Shared constants and types for the max-heap priority queue.
package mhpq_pkg;
   localparam int CAPACITY = 64;
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = 16;
   localparam int TW = 8;

   typedef logic [AW-1:0] addr_type;
   typedef logic [CW-1:0] count_type;

   typedef struct packed {
      logic [PW-1:0] prio;
      logic [TW-1:0] tag;
   } entry_type;

   localparam logic       OP_INSERT  = 1'b0;
   localparam logic       OP_EXTRACT = 1'b1;
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
endpackage

// ===== sv/mhpq_ram.sv =====
// Single-port synchronous RAM holding the heap entries, registered read.
module mhpq_ram (
   input  logic                clock,
   input  logic                we,
   input  mhpq_pkg::addr_type  addr,
   input  mhpq_pkg::entry_type wdata,
   output mhpq_pkg::entry_type rdata
);
   import mhpq_pkg::*;

   entry_type mem [CAPACITY];
   entry_type rdata_ff;

   // write (when we is set) and read one entry per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== sv/max_heap_priority_queue.sv =====
// Top level: max-heap priority queue with a bottom-up rebuild sequencer.
//
//  channel | ports                                         | handshake
//  request | req_op, req_new_priority, req_requester       | start & !busy
//  result  | rsp_status, rsp_out_priority, rsp_out_requester,
//          | rsp_occupancy                                  | rsp_valid, one cycle
//
// One single-port RAM; each sift step reads node, left, right in turn (data
// from the registered RAM output) and may write two entries. A step runs
// S_RD_N, S_RD_L, S_RD_R and S_CMP, plus S_W_BEST with a swap; an operation's
// length is set by the rebuild loop over (n-1)/2 .. 0 and its sift chains.
// Reset clears count and control only; RAM content is not cleared.
// busy is high from accept until the result beat; the receiver cannot stall.
module max_heap_priority_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_op,
   input  logic [mhpq_pkg::PW-1:0]     req_new_priority,
   input  logic [mhpq_pkg::TW-1:0]     req_requester,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [mhpq_pkg::PW-1:0]     rsp_out_priority,
   output logic [mhpq_pkg::TW-1:0]     rsp_out_requester,
   output logic [mhpq_pkg::CW-1:0]     rsp_occupancy
);
   import mhpq_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_X_RD0, S_X_RDL, S_X_W0, S_X_WL, S_RB_INIT,
      S_RD_N, S_RD_L, S_RD_R, S_CMP, S_W_BEST, S_DONE
   } state_type;

   state_type state_ff;
   count_type count_ff;
   addr_type  outer_ff, node_ff, best_ff;
   entry_type nd_ff, lf_ff;
   logic      rsp_valid_ff;
   logic [1:0] status_ff;
   entry_type out_ff;

   logic      we;
   addr_type  addr;
   entry_type wdata, rdata;

   mhpq_ram u_ram (.clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

   // child indices, computed wide to detect the bound
   logic [CW:0] left_w, right_w;
   assign left_w  = {node_ff, 1'b1} + (CW+1)'(0);
   assign right_w = left_w + (CW+1)'(1);
   logic has_l, has_r;
   assign has_l = left_w  < {1'b0, count_ff};
   assign has_r = right_w < {1'b0, count_ff};
   addr_type last_a;
   assign last_a = AW'(count_ff - CW'(1));

   addr_type  best_cmp;
   entry_type best_e;

   // RAM port control
   always_comb begin
      we = 1'b0; addr = node_ff; wdata = nd_ff;
      case (state_ff)
         S_IDLE:   begin we = start && !busy && req_op == OP_INSERT
                            && count_ff < CW'(CAPACITY);
                         addr = AW'(count_ff);
                         wdata = entry_type'({req_new_priority, req_requester}); end
         S_X_RD0:  addr = '0;
         S_X_RDL:  addr = last_a;
         S_X_W0:   begin we = 1'b1; addr = '0; wdata = rdata; end
         S_X_WL:   begin we = 1'b1; addr = last_a; wdata = nd_ff; end
         S_RD_N:   addr = node_ff;
         S_RD_L:   addr = left_w[AW-1:0];
         S_RD_R:   addr = right_w[AW-1:0];
         S_CMP:    begin we = (best_cmp != node_ff); addr = node_ff; wdata = best_e; end
         S_W_BEST: begin we = 1'b1; addr = best_ff; wdata = nd_ff; end
         default:  ;
      endcase
   end

   // largest of node and children; node wins ties, then left wins over right
   always_comb begin
      best_cmp = node_ff; best_e = nd_ff;
      if (has_l && lf_ff.prio > best_e.prio) begin
         best_cmp = left_w[AW-1:0]; best_e = lf_ff;
      end
      if (has_r && rdata.prio > best_e.prio) begin
         best_cmp = right_w[AW-1:0]; best_e = rdata;
      end
   end

   assign busy = state_ff != S_IDLE;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == S_DONE);
         case (state_ff)
            S_IDLE: if (start) begin
               out_ff <= '0;
               if (req_op == OP_INSERT) begin
                  if (count_ff >= CW'(CAPACITY)) begin
                     status_ff <= ST_FULL; state_ff <= S_DONE;
                  end else begin
                     status_ff <= ST_OK;
                     count_ff <= count_ff + CW'(1); state_ff <= S_RB_INIT;
                  end
               end else if (count_ff == '0) begin
                  status_ff <= ST_EMPTY; state_ff <= S_DONE;
               end else begin
                  status_ff <= ST_OK; state_ff <= S_X_RD0;
               end
            end
            S_X_RD0: state_ff <= S_X_RDL;
            S_X_RDL: begin nd_ff <= rdata; state_ff <= S_X_W0; end
            S_X_W0:  state_ff <= S_X_WL;
            S_X_WL:  begin out_ff <= nd_ff; count_ff <= count_ff - CW'(1);
                        state_ff <= S_RB_INIT; end
            S_RB_INIT: if (count_ff == '0) state_ff <= S_DONE;
               else begin
                  outer_ff <= AW'((count_ff - CW'(1)) >> 1);
                  node_ff <= AW'((count_ff - CW'(1)) >> 1);
                  state_ff <= S_RD_N;
               end
            S_RD_N: state_ff <= S_RD_L;
            S_RD_L: begin nd_ff <= rdata; state_ff <= S_RD_R; end
            S_RD_R: begin lf_ff <= rdata; state_ff <= S_CMP; end
            S_CMP: if (best_cmp != node_ff) begin
                  best_ff <= best_cmp; state_ff <= S_W_BEST;
               end else if (outer_ff == '0) state_ff <= S_DONE;
               else begin
                  outer_ff <= outer_ff - AW'(1); node_ff <= outer_ff - AW'(1);
                  state_ff <= S_RD_N;
               end
            S_W_BEST: begin node_ff <= best_ff; state_ff <= S_RD_N; end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_out_priority  = out_ff.prio;
   assign rsp_out_requester = out_ff.tag;
   assign rsp_occupancy     = count_ff;

   // count never exceeds capacity
   a_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("count over capacity");
   // a result beat always returns to idle
   a_ret: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   // full status leaves count at capacity
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_occupancy == CW'(CAPACITY))
      else $error("full with room");
   // empty status leaves zero entries
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_occupancy == '0)
      else $error("empty with entries");
endmodule
